[src/hcs_pkg.sv]
// Shared types and constants for the histogram contrast stretch block.
package hcs_pkg;

	localparam int PIX_W = 8;
	localparam logic [7:0] PIX_MAX = 8'd255;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_COUNT = 2'd1,
		OP_MAP   = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_REJECTED = 2'd1,
		ST_DEGEN    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_MANUAL_LOW  = 2'd0,
		REG_MANUAL_HIGH = 2'd1,
		REG_AUTO_LOW    = 2'd2,
		REG_AUTO_HIGH   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] pixel_in;
	} in_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic [1:0] status;
		logic [7:0] low_used;
		logic [7:0] high_used;
	} out_t;

	// classified map request handed from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pix;
		logic [7:0] lo;
		logic [7:0] hi;
	} job_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} bk_state_t;

endpackage

[src/hcs_front.sv]
// Front end: accepts requests, keeps statistics, resolves bounds, queues map jobs.
module hcs_front #(
	parameter int QDEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  hcs_pkg::in_t   in_data,
	input  logic [7:0]     manual_low,
	input  logic [7:0]     manual_high,
	input  logic           auto_low,
	input  logic           auto_high,
	output logic           job_valid,
	input  logic           job_take,
	output hcs_pkg::job_t  job
);
	localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	logic [7:0] seen_lo_q, seen_hi_q;
	logic seen_any_q;
	hcs_pkg::job_t q_q [QDEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;
	logic acc, push;
	hcs_pkg::job_t nj;
	logic [7:0] lo, hi;

	assign in_stall = (cnt_q == (AW+1)'(QDEPTH));
	assign acc = in_valid && !in_stall;
	assign push = acc && (in_data.op == hcs_pkg::OP_MAP);
	assign job_valid = (cnt_q != '0);
	assign job = q_q[rd_q];

	always_comb begin
		lo = (auto_low && seen_any_q) ? seen_lo_q : manual_low;
		hi = (auto_high && seen_any_q) ? seen_hi_q : manual_high;
		nj.pix = in_data.pixel_in;
		if (manual_low >= manual_high) begin
			nj.kind = hcs_pkg::ST_REJECTED;
			nj.lo = '0;
			nj.hi = '0;
		end else begin
			nj.kind = (lo == hi) ? hcs_pkg::ST_DEGEN : hcs_pkg::ST_OK;
			nj.lo = lo;
			nj.hi = hi;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_lo_q <= hcs_pkg::PIX_MAX;
			seen_hi_q <= '0;
			seen_any_q <= 1'b0;
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (acc && in_data.op == hcs_pkg::OP_CLEAR) begin
				seen_lo_q <= hcs_pkg::PIX_MAX;
				seen_hi_q <= '0;
				seen_any_q <= 1'b0;
			end
			if (acc && in_data.op == hcs_pkg::OP_COUNT) begin
				if (in_data.pixel_in < seen_lo_q) seen_lo_q <= in_data.pixel_in;
				if (in_data.pixel_in > seen_hi_q) seen_hi_q <= in_data.pixel_in;
				seen_any_q <= 1'b1;
			end
			if (push) wr_q <= (wr_q == AW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			if (job_take) rd_q <= (rd_q == AW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(job_take);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= nj;
	end
endmodule

[src/hcs_back.sv]
// Back end: serial signed division of the stretch formula and result register.
module hcs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_take,
	input  hcs_pkg::job_t  job,
	output logic           out_valid,
	input  logic           out_stall,
	output hcs_pkg::out_t  out_data
);
	// |256*(p-lo)| < 2^16, |hi-lo| < 2^8
	hcs_pkg::bk_state_t st_q, st_d;
	logic [15:0] quo_q;
	logic [8:0] rem_q;
	logic [7:0] den_q;
	logic neg_q;
	logic [4:0] cnt_q;
	hcs_pkg::job_t j_q;
	hcs_pkg::out_t res_q;
	logic vld_q;

	logic signed [9:0] num_s, den_s;
	logic [8:0] rtrial;
	logic [9:0] rsub;
	logic [7:0] pix;

	assign num_s = $signed({2'b00, job.pix}) - $signed({2'b00, job.lo});
	assign den_s = $signed({2'b00, job.hi}) - $signed({2'b00, job.lo});
	assign rtrial = {rem_q[7:0], quo_q[15]};
	assign rsub = {1'b0, rtrial} - {2'b00, den_q};
	assign out_valid = vld_q;
	assign out_data = res_q;

	always_comb begin
		st_d = st_q;
		job_take = 1'b0;
		unique case (st_q)
			hcs_pkg::BK_IDLE: if (job_valid) begin
				job_take = 1'b1;
				if (job.kind == hcs_pkg::ST_OK) st_d = hcs_pkg::BK_DIV;
				else st_d = hcs_pkg::BK_DONE;
			end
			hcs_pkg::BK_DIV: if (cnt_q == 5'd15) st_d = hcs_pkg::BK_DONE;
			hcs_pkg::BK_DONE: if (!vld_q || !out_stall) st_d = hcs_pkg::BK_IDLE;
			default: st_d = hcs_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		pix = '0;
		if (j_q.kind == hcs_pkg::ST_DEGEN) pix = (j_q.pix >= j_q.lo) ? hcs_pkg::PIX_MAX : '0;
		else if (j_q.kind == hcs_pkg::ST_OK) begin
			if (neg_q && quo_q != '0) pix = '0;
			else if (quo_q > 16'd255) pix = hcs_pkg::PIX_MAX;
			else pix = quo_q[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= hcs_pkg::BK_IDLE;
			vld_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == hcs_pkg::BK_DONE && (!vld_q || !out_stall)) vld_q <= 1'b1;
			else if (!out_stall) vld_q <= 1'b0;
			if (st_q == hcs_pkg::BK_DIV) cnt_q <= cnt_q + 1'b1;
			else cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (job_take) begin
			j_q <= job;
			neg_q <= num_s[9] ^ den_s[9];
			quo_q <= {(num_s[9] ? 8'(-num_s) : num_s[7:0]), 8'h00};
			den_q <= den_s[9] ? 8'(-den_s) : den_s[7:0];
			rem_q <= '0;
		end else if (st_q == hcs_pkg::BK_DIV) begin
			if (!rsub[9]) begin
				rem_q <= rsub[8:0];
				quo_q <= {quo_q[14:0], 1'b1};
			end else begin
				rem_q <= rtrial;
				quo_q <= {quo_q[14:0], 1'b0};
			end
		end
		if (st_q == hcs_pkg::BK_DONE && (!vld_q || !out_stall)) begin
			res_q.pixel_out <= pix;
			res_q.status <= j_q.kind;
			res_q.low_used <= j_q.lo;
			res_q.high_used <= j_q.hi;
		end
	end
endmodule

[src/histogram_contrast_stretch.sv]
// Top level of the histogram contrast stretch block.
// Clear and count requests are absorbed by the front end, which keeps the running
// lowest and highest level. Each map request queues a job for the back end, whose
// restoring divider handles a normal stretch; rejected and equal-bound maps skip
// the division. A job queue of QDEPTH entries (two by default) lets counting
// continue while a division runs.
module histogram_contrast_stretch #(
	parameter int QDEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hcs_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output hcs_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);
	logic [7:0] man_lo_q, man_hi_q;
	logic auto_lo_q, auto_hi_q;
	logic job_valid, job_take;
	hcs_pkg::job_t job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			man_lo_q <= '0;
			man_hi_q <= hcs_pkg::PIX_MAX;
			auto_lo_q <= 1'b0;
			auto_hi_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (hcs_pkg::reg_idx_t'(cfg_index))
				hcs_pkg::REG_MANUAL_LOW:  man_lo_q <= cfg_data;
				hcs_pkg::REG_MANUAL_HIGH: man_hi_q <= cfg_data;
				hcs_pkg::REG_AUTO_LOW:    auto_lo_q <= cfg_data[0];
				hcs_pkg::REG_AUTO_HIGH:   auto_hi_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	hcs_front #(.QDEPTH(QDEPTH)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.manual_low(man_lo_q), .manual_high(man_hi_q),
		.auto_low(auto_lo_q), .auto_high(auto_hi_q),
		.job_valid, .job_take, .job
	);

	hcs_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job,
		.out_valid, .out_stall, .out_data
	);
endmodule

[tb/tb_histogram_contrast_stretch.sv]
// Self-checking testbench for the histogram contrast stretch block.
`timescale 1ns / 100ps

module tb_histogram_contrast_stretch;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	hcs_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	hcs_pkg::out_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	histogram_contrast_stretch u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [7:0] m_low, m_high, st_low, st_high;
	logic a_low, a_high, st_any;
	hcs_pkg::out_t stretched_q[$];
	int mismatches = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_set = 0;
	hcs_pkg::out_t hold_val;

	typedef struct {
		hcs_pkg::op_t op;
		logic [7:0] pix;
		bit typed;
		hcs_pkg::out_t res;
	} row_t;

	function automatic hcs_pkg::out_t stretch_pixel(logic [7:0] p);
		hcs_pkg::out_t r;
		logic [7:0] lo, hi;
		longint v;
		r = '0;
		if (m_low >= m_high) begin
			r.status = hcs_pkg::ST_REJECTED;
			return r;
		end
		lo = (a_low && st_any) ? st_low : m_low;
		hi = (a_high && st_any) ? st_high : m_high;
		r.low_used = lo;
		r.high_used = hi;
		if (lo == hi) begin
			r.pixel_out = (p >= lo) ? 8'd255 : 8'd0;
			r.status = hcs_pkg::ST_DEGEN;
		end else begin
			v = (longint'(256) * (longint'(p) - longint'(lo)))
				/ (longint'(hi) - longint'(lo));
			if (v < 0) v = 0;
			if (v > 255) v = 255;
			r.pixel_out = v[7:0];
			r.status = hcs_pkg::ST_OK;
		end
		return r;
	endfunction

	task automatic send_pixel(hcs_pkg::op_t op, logic [7:0] p, bit typed,
			hcs_pkg::out_t res);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 7);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= {op, p};
		@(negedge clk);
		while (in_stall) @(negedge clk);
		@(posedge clk);
		case (op)
			hcs_pkg::OP_CLEAR: begin
				st_low = 8'd255;
				st_high = 8'd0;
				st_any = 1'b0;
			end
			hcs_pkg::OP_COUNT: begin
				if (p < st_low) st_low = p;
				if (p > st_high) st_high = p;
				st_any = 1'b1;
			end
			hcs_pkg::OP_MAP: begin
				if (typed && res != stretch_pixel(p))
					$display("directed row disagrees with predictor for pixel %0d", p);
				stretched_q.push_back(typed ? res : stretch_pixel(p));
			end
			default: ;
		endcase
	endtask

	task automatic write_reg(hcs_pkg::reg_idx_t idx, logic [7:0] val);
		in_valid <= 1'b0;
		while (stretched_q.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			hcs_pkg::REG_MANUAL_LOW: m_low = val;
			hcs_pkg::REG_MANUAL_HIGH: m_high = val;
			hcs_pkg::REG_AUTO_LOW: a_low = val[0];
			default: a_high = val[0];
		endcase
	endtask

	task automatic set_bounds(logic [7:0] lo, logic [7:0] hi, bit al, bit ah);
		write_reg(hcs_pkg::REG_MANUAL_LOW, lo);
		write_reg(hcs_pkg::REG_MANUAL_HIGH, hi);
		write_reg(hcs_pkg::REG_AUTO_LOW, {7'd0, al});
		write_reg(hcs_pkg::REG_AUTO_HIGH, {7'd0, ah});
	endtask

	// stall generator
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		hcs_pkg::out_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid) begin
			if (hold_set && out_data != hold_val) begin
				mismatches++;
				if (mismatches <= 10)
					$display("stalled result changed: %h -> %h", hold_val, out_data);
			end
			hold_set <= out_stall;
			hold_val <= out_data;
		end else begin
			hold_set <= 1'b0;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (stretched_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", out_data);
			end else begin
				want = stretched_q.pop_front();
				if (want != out_data) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected pix %0d st %0d lo %0d hi %0d,",
							" got pix %0d st %0d lo %0d hi %0d"},
							want.pixel_out, want.status, want.low_used, want.high_used,
							out_data.pixel_out, out_data.status,
							out_data.low_used, out_data.high_used);
				end
			end
		end
		if (cycles > 400000) begin
			$display("FAIL");
			$finish;
		end
	end

	row_t directed[$];
	initial begin
		hcs_pkg::out_t r;
		hcs_pkg::op_t op;
		int k, n;
		m_low = 8'd0; m_high = 8'd255; a_low = 1'b0; a_high = 1'b0;
		st_low = 8'd255; st_high = 8'd0; st_any = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: identity-like stretch over 0..255
		directed.push_back('{hcs_pkg::OP_MAP, 8'd0, 1,
			'{8'd0, hcs_pkg::ST_OK, 8'd0, 8'd255}});
		directed.push_back('{hcs_pkg::OP_MAP, 8'd255, 1,
			'{8'd255, hcs_pkg::ST_OK, 8'd0, 8'd255}});
		directed.push_back('{hcs_pkg::OP_MAP, 8'd128, 1,
			'{8'd128, hcs_pkg::ST_OK, 8'd0, 8'd255}});
		directed.push_back('{hcs_pkg::OP_NONE, 8'hAA, 0, '0});
		directed.push_back('{hcs_pkg::OP_COUNT, 8'd40, 0, '0});
		directed.push_back('{hcs_pkg::OP_COUNT, 8'd200, 0, '0});
		directed.push_back('{hcs_pkg::OP_MAP, 8'h55, 0, '0});
		directed.push_back('{hcs_pkg::OP_CLEAR, 8'd0, 0, '0});
		foreach (directed[i])
			send_pixel(directed[i].op, directed[i].pix, directed[i].typed, directed[i].res);

		// rejected manual bounds
		set_bounds(8'd100, 8'd100, 0, 0);
		r = '0; r.status = hcs_pkg::ST_REJECTED;
		send_pixel(hcs_pkg::OP_MAP, 8'd7, 1, r);
		set_bounds(8'd255, 8'd0, 1, 1);
		send_pixel(hcs_pkg::OP_MAP, 8'd255, 1, r);
		// auto bounds with and without counted pixels, equal bounds and pixels outside the bounds
		set_bounds(8'd10, 8'd20, 1, 1);
		send_pixel(hcs_pkg::OP_MAP, 8'd15, 0, '0);
		send_pixel(hcs_pkg::OP_COUNT, 8'd50, 0, '0);
		send_pixel(hcs_pkg::OP_MAP, 8'd50, 1, '{8'd255, hcs_pkg::ST_DEGEN, 8'd50, 8'd50});
		send_pixel(hcs_pkg::OP_MAP, 8'd49, 1, '{8'd0, hcs_pkg::ST_DEGEN, 8'd50, 8'd50});
		set_bounds(8'd0, 8'd254, 1, 0);
		send_pixel(hcs_pkg::OP_COUNT, 8'd254, 0, '0);
		send_pixel(hcs_pkg::OP_MAP, 8'd0, 0, '0);
		send_pixel(hcs_pkg::OP_MAP, 8'd255, 0, '0);
		send_pixel(hcs_pkg::OP_CLEAR, 8'd0, 0, '0);

		for (k = 0; k < 12; k++) begin
			if (k == 11) quiet = 1;
			case (k % 4)
				0: set_bounds(8'($urandom_range(0, 254)), 8'd255,
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				1: set_bounds(8'd0, 8'($urandom_range(1, 255)), 1, 1);
				2: set_bounds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				default: set_bounds(8'($urandom_range(0, 120)),
					8'($urandom_range(130, 255)), 0, 1);
			endcase
			for (n = 0; n < 125; n++) begin
				case ($urandom_range(0, 15))
					0: op = hcs_pkg::OP_CLEAR;
					1: op = hcs_pkg::OP_NONE;
					2, 3, 4, 5, 6: op = hcs_pkg::OP_COUNT;
					default: op = hcs_pkg::OP_MAP;
				endcase
				send_pixel(op, 8'($urandom_range(0, 255)), 0, '0);
			end
		end
		in_valid <= 1'b0;

		n = 0;
		while (stretched_q.size() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		repeat (40) @(posedge clk);
		if (mismatches == 0 && stretched_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
